// ===== sv/gfi_pkg.sv =====
// types and constants shared by the fan index generator modules
// no dependencies
`default_nettype none

package gfi_pkg;

    localparam int VTX_W  = 21;
    localparam int POS_W  = 24;
    localparam int GW_W   = 13;
    localparam int PS_W   = 9;
    localparam int XZ_W   = 9;
    localparam int LOD_W  = 3;
    localparam int STEP_W = 8;
    localparam int CFG_IDX_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_SIZE = 4'd1;

    // fan sides in emission order
    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_TOP    = 2'd1;
    localparam logic [1:0] SIDE_RIGHT  = 2'd2;
    localparam logic [1:0] SIDE_BOTTOM = 2'd3;

    typedef struct packed {
        logic [XZ_W-1:0]  fan_x;
        logic [XZ_W-1:0]  fan_z;
        logic [LOD_W-1:0] core_lod;
        logic             left_coarse;
        logic             right_coarse;
        logic             top_coarse;
        logic             bottom_coarse;
    } t_fan_in;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_center;
        logic [VTX_W-1:0] vertex_first;
        logic [VTX_W-1:0] vertex_second;
        logic [POS_W-1:0] buffer_position;
        logic             last_triangle;
    } t_tri_out;

    // classified fan, passed from front to back
    typedef struct packed {
        logic [VTX_W-1:0]  base;     // corner vertex index
        logic [VTX_W-1:0]  center;
        logic [VTX_W-1:0]  step_row; // half-step times grid width
        logic [STEP_W-1:0] step_col; // half-step
        logic [3:0]        merge;    // indexed by side code
    } t_fan;

endpackage

`default_nettype wire

// ===== sv/gfi_fifo.sv =====
// small register queue with full and empty flags
// no dependencies
`default_nettype none

module gfi_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_rd,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [AW:0]   r_cnt;
    logic          wr_ok, rd_ok;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_ok) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (rd_ok) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/gfi_front.sv =====
// front end: edge tests, half-step and corner/center vertex indices per fan
// depends on gfi_pkg
`default_nettype none

module gfi_front
    import gfi_pkg::*;
#(
    parameter int MAX_CORE_LOD = 7
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [GW_W-1:0] i_grid_width,
    input  wire logic [PS_W-1:0] i_patch_size,
    input  wire logic            i_push,
    input  wire t_fan_in         i_fan,
    output logic                 o_full,
    output logic                 o_wr,
    output t_fan                 o_fan,
    input  wire logic            i_q_full
);
    logic               r_v;
    logic [VTX_W-1:0]   r_prod;
    logic [XZ_W-1:0]    r_x;
    logic [STEP_W-1:0]  r_s;
    logic [VTX_W-1:0]   r_sr;
    logic [3:0]         r_merge;

    logic               accept;
    logic [LOD_W-1:0]   core;
    logic [STEP_W-1:0]  s;
    logic [STEP_W:0]    s2;
    logic [PS_W+1:0]    endpos;
    logic [3:0]         merge;
    logic [VTX_W-1:0]   base;

    always_comb begin
        if ({1'b0, i_fan.core_lod} > 4'(MAX_CORE_LOD)) begin
            core = LOD_W'(MAX_CORE_LOD);
        end else begin
            core = i_fan.core_lod;
        end
        s  = STEP_W'(1) << core;
        s2 = {s, 1'b0};
        // a negative position wraps to a value with its top bits set, never equal to x or z
        endpos = {2'b00, i_patch_size} - (PS_W+2)'(1) - {2'b00, s2};
        merge[SIDE_LEFT]   = i_fan.left_coarse && (i_fan.fan_x == '0);
        merge[SIDE_BOTTOM] = i_fan.bottom_coarse && (i_fan.fan_z == '0);
        merge[SIDE_RIGHT]  = i_fan.right_coarse && ({2'b00, i_fan.fan_x} == endpos);
        merge[SIDE_TOP]    = i_fan.top_coarse && ({2'b00, i_fan.fan_z} == endpos);
    end

    assign o_full = r_v && i_q_full;
    assign accept = i_push && !o_full;
    assign o_wr   = r_v && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (o_wr) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod  <= VTX_W'(i_fan.fan_z) * VTX_W'(i_grid_width);
            r_x     <= i_fan.fan_x;
            r_s     <= s;
            r_sr    <= VTX_W'(i_grid_width) << core;
            r_merge <= merge;
        end
    end

    always_comb begin
        base          = r_prod + VTX_W'(r_x);
        o_fan.base     = base;
        o_fan.center   = base + r_sr + VTX_W'(r_s);
        o_fan.step_row = r_sr;
        o_fan.step_col = r_s;
        o_fan.merge    = r_merge;
    end

endmodule

`default_nettype wire

// ===== sv/gfi_back.sv =====
// back end: walks the fan rim and emits one triangle per cycle while the output queue is not full
// depends on gfi_pkg
`default_nettype none

module gfi_back
    import gfi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_fan i_fan,
    output logic      o_q_rd,
    output logic      o_wr,
    output t_tri_out  o_tri,
    input  wire logic i_out_full
);
    logic             r_active;
    t_fan             r_item;
    logic [1:0]       r_side;
    logic             r_half;
    logic [VTX_W-1:0] r_cur;
    logic [POS_W-1:0] r_wpos;

    logic             merged;
    logic             last;
    logic             done;
    logic [VTX_W-1:0] rstep, cstep, second;

    always_comb begin
        merged = r_item.merge[r_side];
        rstep  = merged ? {r_item.step_row[VTX_W-2:0], 1'b0} : r_item.step_row;
        cstep  = merged ? VTX_W'({r_item.step_col, 1'b0}) : VTX_W'(r_item.step_col);
        case (r_side)
            SIDE_LEFT:   second = r_cur + rstep;
            SIDE_TOP:    second = r_cur + cstep;
            SIDE_RIGHT:  second = r_cur - rstep;
            SIDE_BOTTOM: second = r_cur - cstep;
            default:     second = r_cur;
        endcase
        last = (r_side == SIDE_BOTTOM) && (merged || r_half);
    end

    assign o_wr   = r_active && !i_out_full;
    assign done   = o_wr && last;
    assign o_q_rd = (!r_active || done) && !i_q_empty;

    always_comb begin
        o_tri.vertex_center   = r_item.center;
        o_tri.vertex_first    = r_cur;
        o_tri.vertex_second   = second;
        o_tri.buffer_position = r_wpos;
        o_tri.last_triangle   = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_side   <= SIDE_LEFT;
            r_half   <= 1'b0;
            r_wpos   <= '0;
        end else begin
            if (o_wr) begin
                r_wpos <= r_wpos + POS_W'(3);
                if (merged || r_half) begin
                    r_side <= r_side + 2'd1;
                    r_half <= 1'b0;
                end else begin
                    r_half <= 1'b1;
                end
            end
            if (o_q_rd) begin
                r_active <= 1'b1;
                r_side   <= SIDE_LEFT;
                r_half   <= 1'b0;
            end else if (done) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_item <= i_fan;
            r_cur  <= i_fan.base;
        end else if (o_wr) begin
            r_cur <= second;
        end
    end

    // buffer position moves by one triangle per emitted item
    a_wpos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr |=> r_wpos == $past(r_wpos) + POS_W'(3))
        else $error("buffer position did not advance by 3");

    // a merged side never has a second triangle
    a_half_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_half) |-> !merged)
        else $error("second triangle on a merged side");

    // the rim walk closes on the corner vertex
    a_rim_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> second == r_item.base)
        else $error("fan rim did not return to its corner");

endmodule

`default_nettype wire

// ===== sv/geomipmap_fan_index_generator.sv =====
// top level of the geomipmap triangle fan index generator
// depends on gfi_pkg, gfi_front, gfi_back, gfi_fifo
`default_nettype none

// Takes one triangle fan per item and emits its 4 to 8 triangles, one per
// clock cycle while the result queue has room, in the order left, top,
// right, bottom, from the back end's rim walker, which does one vertex add
// per triangle. The front end classifies the next fans while the back
// end is still emitting, with a two-entry queue between them and a two-entry
// result queue at the output, so push is taken every cycle until those fill.
// With nothing ahead, a fan passes the front end register, the fan queue,
// the back end walker and the result queue before its first triangle shows.
// Config writes are always ready and must only happen while the block is idle.
module geomipmap_fan_index_generator
    import gfi_pkg::*;
#(
    parameter int MAX_CORE_LOD = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire t_fan_in              i_fan,
    output logic                      empty,
    input  wire logic                 pop,
    output t_tri_out                  o_tri,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [GW_W-1:0]      i_cfg_data
);
    logic [GW_W-1:0] r_grid_width;
    logic [PS_W-1:0] r_patch_size;

    logic     q_wr, q_full, q_rd, q_empty;
    t_fan     q_wdata, q_rdata;
    logic     out_wr, out_full;
    t_tri_out out_wdata, out_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GW_W'(257);
            r_patch_size <= PS_W'(33);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH: r_grid_width <= i_cfg_data;
                CFG_PATCH_SIZE: r_patch_size <= i_cfg_data[PS_W-1:0];
                default: ;
            endcase
        end
    end

    gfi_front #(
        .MAX_CORE_LOD(MAX_CORE_LOD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grid_width(r_grid_width),
        .i_patch_size(r_patch_size),
        .i_push      (push),
        .i_fan       (i_fan),
        .o_full      (full),
        .o_wr        (q_wr),
        .o_fan       (q_wdata),
        .i_q_full    (q_full)
    );

    gfi_fifo #(
        .W    ($bits(t_fan)),
        .DEPTH(2)
    ) u_fan_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (q_wr),
        .i_wdata(q_wdata),
        .o_full (q_full),
        .i_rd   (q_rd),
        .o_rdata(q_rdata),
        .o_empty(q_empty)
    );

    gfi_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_fan     (q_rdata),
        .o_q_rd    (q_rd),
        .o_wr      (out_wr),
        .o_tri     (out_wdata),
        .i_out_full(out_full)
    );

    gfi_fifo #(
        .W    ($bits(t_tri_out)),
        .DEPTH(2)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (out_wr),
        .i_wdata(out_wdata),
        .o_full (out_full),
        .i_rd   (pop),
        .o_rdata(out_rdata),
        .o_empty(empty)
    );

    assign o_tri = out_rdata;

endmodule

`default_nettype wire
